>>> rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg: shared definitions of the stable sorted priority queue
// Entry layout, status codes, sequencer states and the default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TypeW = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TypeW-1:0] etype;
    logic [TimeW-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_INS,
    ST_POP_RD,
    ST_POP_HEAD,
    ST_POP_NXT,
    ST_POP_MV,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

>>> rtl/stable_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top: time-ordered event queue
// Sorted list in a single-port-write, registered-read memory, walked by a
// small sequencer with one key comparator.
// ----------------------------------------------------------------------------
// Each item is a push (insert event by time, behind equal times) or a pop
// (remove the least-time event), and yields one result with a status and the
// entry count after the operation. The block takes one item at a time. A
// push walks from the tail toward its slot, moving each later entry one slot
// back with a memory read, then a compare and write; a pop reads the head
// and moves the remaining entries one place toward the head. Rejected items
// (push on full, pop on empty) go straight to the finish state. A finished
// result waits in an output register, and the next item may be taken while
// it waits.
`default_nettype none

module stable_sorted_priority_queue_top #(
  parameter int unsigned DEPTH = sspq_pkg::DefaultDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       cmd_i,
  input  wire logic [sspq_pkg::IdW-1:0]   event_id_i,
  input  wire logic [sspq_pkg::TypeW-1:0] event_type_i,
  input  wire logic [sspq_pkg::TimeW-1:0] event_time_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [sspq_pkg::IdW-1:0]        out_id_o,
  output logic [sspq_pkg::TypeW-1:0]      out_type_o,
  output logic [sspq_pkg::TimeW-1:0]      out_time_o,
  output logic [1:0]                      status_o,
  output logic [sspq_pkg::OccW-1:0]       occupancy_o
);
  import sspq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] One      = CntW'(1);

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  entry_t          ent_q, ent_d;
  entry_t          res_q, res_d;
  status_e         res_st_q, res_st_d;

  logic            out_valid_q;
  entry_t          out_ent_q;
  status_e         out_st_q;
  logic [OccW-1:0] out_occ_q;

  entry_t          mem [DEPTH];
  entry_t          rdata_q;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic            wr_en;

  logic            accept;
  logic            out_free;
  logic [CntW-1:0] idx_dec;
  logic [CntW-1:0] idx_inc;
  logic [31:0]     count_ext;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign idx_dec   = idx_q - One;
  assign idx_inc   = idx_q + One;
  assign count_ext = 32'(count_q);

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_PUSH) begin
            if (count_q == DepthCnt) begin
              state_d = ST_FINISH;
            end else if (count_q == '0) begin
              state_d = ST_PUSH_INS;
            end else begin
              state_d = ST_PUSH_RD;
            end
          end else begin
            state_d = (count_q == '0) ? ST_FINISH : ST_POP_RD;
          end
        end
      end
      ST_PUSH_RD:  state_d = ST_PUSH_CMP;
      ST_PUSH_CMP: begin
        if (rdata_q.key > ent_q.key) begin
          state_d = (idx_q == One) ? ST_PUSH_INS : ST_PUSH_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_PUSH_INS: state_d = ST_FINISH;
      ST_POP_RD:   state_d = ST_POP_HEAD;
      ST_POP_HEAD: state_d = (count_q == One) ? ST_FINISH : ST_POP_NXT;
      ST_POP_NXT:  state_d = ST_POP_MV;
      ST_POP_MV:   state_d = (idx_inc == count_q) ? ST_FINISH : ST_POP_NXT;
      ST_FINISH:   state_d = out_free ? ST_IDLE : ST_FINISH;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    ent_d    = ent_q;
    res_d    = res_q;
    res_st_d = res_st_q;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx_q[IdxW-1:0];
    wr_data  = ent_q;
    unique case (state_q)
      ST_IDLE: begin
        ent_d    = '{id: event_id_i, etype: event_type_i, key: event_time_i};
        res_d    = '0;
        res_st_d = STATUS_OK;
        idx_d    = count_q;
        if (cmd_i == CMD_PUSH) begin
          if (count_q == DepthCnt) begin
            res_st_d = STATUS_FULL;
          end
        end else if (count_q == '0) begin
          res_st_d = STATUS_EMPTY;
        end
      end
      ST_PUSH_RD: begin
        rd_addr = idx_dec[IdxW-1:0];
      end
      ST_PUSH_CMP: begin
        wr_en = 1'b1;
        if (rdata_q.key > ent_q.key) begin
          // Stored entry is later than the new one: move it one slot back.
          wr_data = rdata_q;
          idx_d   = idx_dec;
        end else begin
          count_d = count_q + One;
        end
      end
      ST_PUSH_INS: begin
        wr_en   = 1'b1;
        count_d = count_q + One;
      end
      ST_POP_RD: begin
        rd_addr = '0;
      end
      ST_POP_HEAD: begin
        res_d = rdata_q;
        idx_d = One;
        if (count_q == One) begin
          count_d = '0;
        end
      end
      ST_POP_NXT: begin
        rd_addr = idx_q[IdxW-1:0];
      end
      ST_POP_MV: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec[IdxW-1:0];
        wr_data = rdata_q;
        idx_d   = idx_inc;
        if (idx_inc == count_q) begin
          count_d = count_q - One;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    if (accept) begin
      ent_q <= ent_d;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_ent_q <= res_q;
      out_st_q  <= res_st_q;
      out_occ_q <= count_ext[OccW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_ent_q.id;
  assign out_type_o  = out_ent_q.etype;
  assign out_time_o  = out_ent_q.key;
  assign status_o    = out_st_q;
  assign occupancy_o = out_occ_q;

endmodule

`default_nettype wire
